// ===== hw/rtl/point_segment_nearest_distance_macros.svh =====
// ----------------------------------------------------------------------------
// Point-segment distance assertion macros
// Shared assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_NEAREST_DISTANCE_MACROS_SVH
`define POINT_SEGMENT_NEAREST_DISTANCE_MACROS_SVH

// Assert a property on clk_i, quiet while rst_ni is low
`define PSND_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert a property on clk_i at every edge, reset included
`define PSND_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/psnd_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-segment distance package
// Widths, region codes and the records that travel down the cell chains.
// ----------------------------------------------------------------------------
package psnd_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned ProdW    = 2 * DiffW;
  localparam int unsigned SumW     = ProdW + 1;
  localparam int unsigned UBits    = 24;
  localparam int unsigned MinW     = 32;
  localparam int unsigned RadW     = SumW + 1;
  localparam int unsigned RootBits = RadW / 2;
  localparam int unsigned RootRemW = RootBits + 3;
  localparam int unsigned DistW    = CoordW + 1;
  localparam int unsigned Latency  = 10 + UBits + RootBits;

  localparam logic [MinW-1:0] MinSqReset = 32'd4295;

  typedef enum logic [1:0] {
    RegionInterior = 2'd0,
    RegionStart    = 2'd1,
    RegionEnd      = 2'd2,
    RegionDegen    = 2'd3
  } region_e;

  // Record of one request in the division chain
  typedef struct packed {
    logic signed [CoordW-1:0] qx;
    logic signed [CoordW-1:0] qy;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    region_e                  region;
    logic [SumW-1:0]          len;
    logic [SumW-1:0]          rem;
    logic [UBits-1:0]         u;
  } div_t;

  // Record of one request in the square-root chain
  typedef struct packed {
    logic signed [CoordW-1:0] nx;
    logic signed [CoordW-1:0] ny;
    region_e                  region;
    logic [RadW-1:0]          rad;
    logic [RootRemW-1:0]      rem;
    logic [RootBits-1:0]      root;
  } root_t;

endpackage

// ===== hw/rtl/psnd_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// One restoring step of the projection quotient, registered.
// ----------------------------------------------------------------------------
module psnd_div_cell import psnd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  logic          valid_q;
  div_t          data_d, data_q;
  logic [SumW:0] shifted;
  logic [SumW:0] diff;

  // Shift in one quotient bit, subtract when the divisor fits
  always_comb begin
    shifted = {data_i.rem, 1'b0};
    diff    = shifted - {1'b0, data_i.len};
    data_d  = data_i;
    if (shifted >= {1'b0, data_i.len}) begin
      data_d.rem = diff[SumW-1:0];
      data_d.u   = {data_i.u[UBits-2:0], 1'b1};
    end else begin
      data_d.rem = shifted[SumW-1:0];
      data_d.u   = {data_i.u[UBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/psnd_root_cell.sv =====
// ----------------------------------------------------------------------------
// Square-root cell
// One digit-by-digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module psnd_root_cell import psnd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  root_t data_i,
  output logic  valid_o,
  output root_t data_o
);

  logic                valid_q;
  root_t               data_d, data_q;
  logic [RootRemW-1:0] cur;
  logic [RootRemW-1:0] trial;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    cur    = {data_i.rem[RootRemW-3:0], data_i.rad[RadW-1 -: 2]};
    trial  = {1'b0, data_i.root, 2'b01};
    data_d = data_i;
    data_d.rad = {data_i.rad[RadW-3:0], 2'b00};
    if (cur >= trial) begin
      data_d.rem  = cur - trial;
      data_d.root = {data_i.root[RootBits-2:0], 1'b1};
    end else begin
      data_d.rem  = cur;
      data_d.root = {data_i.root[RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/point_segment_nearest_distance.sv =====
// ----------------------------------------------------------------------------
// Point-segment nearest distance
// Nearest point on a segment to a query point, and the distance to it.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the six coordinates and raise start; the request
//   is taken at a clock edge with start high and busy low. busy stays low,
//   so a request may be issued in every cycle.
//   Result channel: done_o is high for exactly one cycle with nearest_x_o,
//   nearest_y_o, dist_res_o and region_o; results leave in request order.
//   The receiver cannot hold results off and the block never needs it to.
//   Requests are taken at one per cycle and pass in order through
//   five front stages, a chain of 24 division cells for the projection
//   parameter, five stages for the nearest point and squared distance, and
//   a chain of 34 square-root cells.
//   Configuration: one register, min_sq_length, written through
//   cfg_valid_i/cfg_ready_o/cfg_data_i; cfg_ready_o is always high.
//   Write it only while no request is in flight.
//   Reset clears every in-flight request and loads min_sq_length with 4295.
// ----------------------------------------------------------------------------
module point_segment_nearest_distance import psnd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] query_x_i,
  input  logic signed [CoordW-1:0] query_y_i,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [MinW-1:0]          cfg_data_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] nearest_x_o,
  output logic signed [CoordW-1:0] nearest_y_o,
  output logic [DistW-1:0]         dist_res_o,
  output logic [1:0]               region_o
);

  logic [MinW-1:0] min_sq_q;

  // Front stage records
  logic  s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  div_t  s0_d, s0_q, s1_d, s1_q, s2_q, s3_q, s4_d, s4_q;
  logic signed [ProdW-1:0] pxx_q, pyy_q, pdx_q, pdy_q;
  logic signed [DiffW-1:0] ax_q, ay_q;
  logic [SumW-1:0]         len_q;
  logic signed [SumW-1:0]  dot_q;

  // Division chain
  logic div_v [UBits+1];
  div_t div_d [UBits+1];

  // Back stage records
  logic s5_v_q, s6_v_q, s7_v_q, s8_v_q, s9_v_q;
  div_t s5_q;
  logic [DiffW+UBits-1:0] mx_q, my_q;
  logic signed [CoordW-1:0] s6_nx_q, s6_ny_q, s7_nx_q, s7_ny_q, s8_nx_q, s8_ny_q;
  logic signed [CoordW-1:0] nx_d, ny_d;
  region_e                  s6_reg_q, s7_reg_q, s8_reg_q;
  logic signed [DiffW-1:0]  ex_q, ey_q;
  logic signed [ProdW-1:0]  sqx_q, sqy_q;
  logic [RadW-1:0]          rad_q;
  logic [DiffW+UBits-1:0]   tx_sum, ty_sum;
  logic [DiffW-1:0]         tx, ty;
  logic [DiffW-1:0]         mag_dx, mag_dy;
  root_t                    s9_q;

  // Square-root chain
  logic  rt_v [RootBits+1];
  root_t rt_d [RootBits+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold the minimum squared length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sq_q <= MinSqReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_sq_q <= cfg_data_i;
    end
  end

  // Valid bits of the plain stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0; s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0;
      s4_v_q <= 1'b0; s5_v_q <= 1'b0; s6_v_q <= 1'b0; s7_v_q <= 1'b0;
      s8_v_q <= 1'b0; s9_v_q <= 1'b0;
    end else begin
      s0_v_q <= start && !busy;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= div_v[UBits];
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
      s8_v_q <= s7_v_q;
      s9_v_q <= s8_v_q;
    end
  end

  // Build the captured request and attach the segment deltas
  always_comb begin
    s0_d    = '0;
    s0_d.qx = query_x_i;
    s0_d.qy = query_y_i;
    s0_d.sx = start_x_i;
    s0_d.sy = start_y_i;
    s0_d.ex = end_x_i;
    s0_d.ey = end_y_i;

    s1_d    = s0_q;
    s1_d.dx = {s0_q.ex[CoordW-1], s0_q.ex} - {s0_q.sx[CoordW-1], s0_q.sx};
    s1_d.dy = {s0_q.ey[CoordW-1], s0_q.ey} - {s0_q.sy[CoordW-1], s0_q.sy};
  end

  // Capture the request, form differences, products and sums
  always_ff @(posedge clk_i) begin
    s0_q     <= s0_d;

    s1_q     <= s1_d;
    ax_q     <= {s0_q.qx[CoordW-1], s0_q.qx} - {s0_q.sx[CoordW-1], s0_q.sx};
    ay_q     <= {s0_q.qy[CoordW-1], s0_q.qy} - {s0_q.sy[CoordW-1], s0_q.sy};

    s2_q     <= s1_q;
    pxx_q    <= s1_q.dx * s1_q.dx;
    pyy_q    <= s1_q.dy * s1_q.dy;
    pdx_q    <= ax_q * s1_q.dx;
    pdy_q    <= ay_q * s1_q.dy;

    s3_q     <= s2_q;
    len_q    <= {1'b0, pxx_q} + {1'b0, pyy_q};
    dot_q    <= {pdx_q[ProdW-1], pdx_q} + {pdy_q[ProdW-1], pdy_q};

    s4_q     <= s4_d;
  end

  // Classify the request and seed the division
  always_comb begin
    s4_d     = s3_q;
    s4_d.len = len_q;
    s4_d.rem = '0;
    s4_d.u   = '0;
    priority if (len_q < {{(SumW-MinW){1'b0}}, min_sq_q}) begin
      s4_d.region = RegionDegen;
    end else if (dot_q <= 0) begin
      s4_d.region = RegionStart;
    end else if (dot_q >= $signed(len_q)) begin
      s4_d.region = RegionEnd;
    end else begin
      s4_d.region = RegionInterior;
      s4_d.rem    = dot_q;
    end
  end

  assign div_v[0] = s4_v_q;
  assign div_d[0] = s4_q;

  // Chain of division cells, one quotient bit each
  for (genvar i = 0; i < UBits; i++) begin : g_div
    psnd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[i]),
      .data_i  (div_d[i]),
      .valid_o (div_v[i+1]),
      .data_o  (div_d[i+1])
    );
  end

  // Scale the segment by the quotient
  assign mag_dx = div_d[UBits].dx[DiffW-1] ? DiffW'(-div_d[UBits].dx) : div_d[UBits].dx;
  assign mag_dy = div_d[UBits].dy[DiffW-1] ? DiffW'(-div_d[UBits].dy) : div_d[UBits].dy;

  // Round the offsets, halves away from zero
  assign tx_sum = mx_q + (DiffW+UBits)'(1 << (UBits - 1));
  assign ty_sum = my_q + (DiffW+UBits)'(1 << (UBits - 1));
  assign tx     = tx_sum[DiffW+UBits-1 -: DiffW];
  assign ty     = ty_sum[DiffW+UBits-1 -: DiffW];

  // Pick the nearest point by region
  always_comb begin
    unique case (s5_q.region)
      RegionInterior: begin
        nx_d = s5_q.dx[DiffW-1] ? s5_q.sx - $signed(tx[CoordW-1:0])
                                : s5_q.sx + $signed(tx[CoordW-1:0]);
        ny_d = s5_q.dy[DiffW-1] ? s5_q.sy - $signed(ty[CoordW-1:0])
                                : s5_q.sy + $signed(ty[CoordW-1:0]);
      end
      RegionEnd: begin
        nx_d = s5_q.ex;
        ny_d = s5_q.ey;
      end
      default: begin
        nx_d = s5_q.sx;
        ny_d = s5_q.sy;
      end
    endcase
  end

  // Nearest point, offsets to the query, squares and their sum
  always_ff @(posedge clk_i) begin
    s5_q     <= div_d[UBits];
    mx_q     <= div_d[UBits].u * mag_dx;
    my_q     <= div_d[UBits].u * mag_dy;

    s6_nx_q  <= nx_d;
    s6_ny_q  <= ny_d;
    s6_reg_q <= s5_q.region;
    ex_q     <= {s5_q.qx[CoordW-1], s5_q.qx} - {nx_d[CoordW-1], nx_d};
    ey_q     <= {s5_q.qy[CoordW-1], s5_q.qy} - {ny_d[CoordW-1], ny_d};

    s7_nx_q  <= s6_nx_q;
    s7_ny_q  <= s6_ny_q;
    s7_reg_q <= s6_reg_q;
    sqx_q    <= ex_q * ex_q;
    sqy_q    <= ey_q * ey_q;

    s8_nx_q  <= s7_nx_q;
    s8_ny_q  <= s7_ny_q;
    s8_reg_q <= s7_reg_q;
    rad_q    <= {2'b00, sqx_q} + {2'b00, sqy_q};

    s9_q.nx     <= s8_nx_q;
    s9_q.ny     <= s8_ny_q;
    s9_q.region <= s8_reg_q;
    s9_q.rad    <= rad_q;
    s9_q.rem    <= '0;
    s9_q.root   <= '0;
  end

  assign rt_v[0] = s9_v_q;
  assign rt_d[0] = s9_q;

  // Chain of square-root cells, one root bit each
  for (genvar j = 0; j < RootBits; j++) begin : g_root
    psnd_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rt_v[j]),
      .data_i  (rt_d[j]),
      .valid_o (rt_v[j+1]),
      .data_o  (rt_d[j+1])
    );
  end

  assign done_o      = rt_v[RootBits];
  assign nearest_x_o = rt_d[RootBits].nx;
  assign nearest_y_o = rt_d[RootBits].ny;
  assign dist_res_o  = rt_d[RootBits].root[DistW-1:0];
  assign region_o    = rt_d[RootBits].region;

endmodule

// ===== hw/rtl/psnd_checker.sv =====
// ----------------------------------------------------------------------------
// Point-segment distance checker
// Port-level checks on request/result timing and clamped answers.
// ----------------------------------------------------------------------------
`include "point_segment_nearest_distance_macros.svh"

module psnd_checker import psnd_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic signed [CoordW-1:0] start_x_i,
  input logic signed [CoordW-1:0] end_x_i,
  input logic                     done_o,
  input logic signed [CoordW-1:0] nearest_x_o,
  input logic [1:0]               region_o
);

  // Every request yields a result after the fixed latency, and only then
  `PSND_ASSERT(a_req_to_result, (start && !busy) |-> ##Latency done_o, "result missing")
  `PSND_ASSERT(a_result_from_req, done_o |-> $past(start && !busy, Latency), "spurious result")

  // Clamped and degenerate answers are the segment's end points
  `PSND_ASSERT(a_start_answer, (done_o && (region_o == RegionStart || region_o == RegionDegen)) |-> nearest_x_o == $past(start_x_i, Latency), "start point expected")
  `PSND_ASSERT(a_end_answer, (done_o && region_o == RegionEnd) |-> nearest_x_o == $past(end_x_i, Latency), "end point expected")

  // No result strobe while in reset
  `PSND_ASSERT_ALWAYS(a_quiet_reset, !rst_ni |-> !done_o, "result during reset")

endmodule

bind point_segment_nearest_distance psnd_checker u_psnd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .start_x_i   (start_x_i),
  .end_x_i     (end_x_i),
  .done_o      (done_o),
  .nearest_x_o (nearest_x_o),
  .region_o    (region_o)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Point-segment nearest distance testbench
// Drives query points and segments through the command port and checks each
// nearest point, distance and region code against a wide-arithmetic
// predictor. The threshold register is swept through several settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import psnd_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [127:0]      wide_t;

  typedef struct {
    coord_t qx, qy, sx, sy, ex, ey;
  } request_t;

  typedef struct {
    coord_t           nx, ny;
    logic [DistW-1:0] dist_val;
    region_e          region;
  } nearest_t;

  // Holds the predicted results in request order and compares arrivals
  class nearest_scoreboard;
    logic [MinW-1:0] min_sq;
    nearest_t        pending[$];
    int unsigned     mismatches;
    int unsigned     matched;
    int unsigned     region_seen[4];

    function new();
      min_sq     = MinSqReset;
      mismatches = 0;
      matched    = 0;
    endfunction

    // Floor of the square root of a non-negative value
    function logic [63:0] floor_root(logic [127:0] val);
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] sq;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        sq    = {64'd0, trial} * {64'd0, trial};
        if (sq <= val) root = trial;
      end
      return root;
    endfunction

    // Move from the start coordinate by the rounded fraction of the delta
    function coord_t along(wide_t s, wide_t d, logic [UBits-1:0] u);
      wide_t mag;
      wide_t t;
      mag = (d < 0) ? -d : d;
      t   = ($signed({104'd0, u}) * mag + (128'sd1 <<< (UBits - 1))) >>> UBits;
      return coord_t'((d < 0) ? s - t : s + t);
    endfunction

    function void note_request(request_t r);
      wide_t            qx, qy, sx, sy, ex, ey, dx, dy, len, dot, ox, oy;
      nearest_t         exp;
      logic [UBits-1:0] u;
      logic [63:0]      root;
      qx = r.qx; qy = r.qy; sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey;
      dx  = ex - sx;
      dy  = ey - sy;
      len = dx * dx + dy * dy;
      dot = (qx - sx) * dx + (qy - sy) * dy;
      if (len < $signed({96'd0, min_sq})) begin
        exp.nx = r.sx; exp.ny = r.sy; exp.region = RegionDegen;
      end else if (dot <= 0) begin
        exp.nx = r.sx; exp.ny = r.sy; exp.region = RegionStart;
      end else if (dot >= len) begin
        exp.nx = r.ex; exp.ny = r.ey; exp.region = RegionEnd;
      end else begin
        u = UBits'((dot <<< UBits) / len);
        exp.nx     = along(sx, dx, u);
        exp.ny     = along(sy, dy, u);
        exp.region = RegionInterior;
      end
      ox = exp.nx;
      oy = exp.ny;
      ox = qx - ox;
      oy = qy - oy;
      root         = floor_root(ox * ox + oy * oy);
      exp.dist_val = root[DistW-1:0];
      pending.push_back(exp);
    endfunction

    function void check_result(coord_t nx, coord_t ny, logic [DistW-1:0] dist_val,
                               logic [1:0] region);
      nearest_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result nx=%0d ny=%0d dist=%0d region=%0d",
                   nx, ny, dist_val, region);
        return;
      end
      exp = pending.pop_front();
      if (nx !== exp.nx || ny !== exp.ny || dist_val !== exp.dist_val ||
          region !== exp.region) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: exp nx=%0d ny=%0d dist=%0d region=%0d, ",
                    "got nx=%0d ny=%0d dist=%0d region=%0d"},
                   exp.nx, exp.ny, exp.dist_val, exp.region,
                   nx, ny, dist_val, region);
      end else begin
        matched++;
        region_seen[region]++;
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 300000;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  coord_t           query_x_i, query_y_i, start_x_i, start_y_i, end_x_i, end_y_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [MinW-1:0]  cfg_data_i;
  logic             done_o;
  coord_t           nearest_x_o, nearest_y_o;
  logic [DistW-1:0] dist_res_o;
  logic [1:0]       region_o;

  nearest_scoreboard sb;
  int unsigned       cycles;
  int unsigned       sent;
  bit                calm;

  point_segment_nearest_distance u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .query_x_i   (query_x_i),
    .query_y_i   (query_y_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .nearest_x_o (nearest_x_o),
    .nearest_y_o (nearest_y_o),
    .dist_res_o  (dist_res_o),
    .region_o    (region_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Check every result on its strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(nearest_x_o, nearest_y_o, dist_res_o, region_o);
  end

  // Guard against a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL point_segment_nearest_distance");
      $finish;
    end
  end

  // Issue one request and hold it until taken
  task automatic send_request(request_t r);
    @(negedge clk_i);
    start     = 1'b1;
    query_x_i = r.qx; query_y_i = r.qy;
    start_x_i = r.sx; start_y_i = r.sy;
    end_x_i   = r.ex; end_y_i   = r.ey;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    sent++;
  endtask

  // Drop start for a random gap, unless in the calm stretch
  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 99) < 25) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Write the threshold register while the pipeline is empty
  task automatic write_min_sq(logic [MinW-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.min_sq = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'(32'h8000_0000);
      1: return coord_t'(32'h7fff_ffff);
      2: return '0;
      3: return '1;
      4: return coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Random request: mostly local geometry, some degenerate, edge and wide ones
  function automatic request_t random_request();
    request_t r;
    int       kind;
    int       base_x, base_y, span;
    kind   = $urandom_range(0, 9);
    base_x = $urandom;
    base_y = $urandom;
    span   = 1 << $urandom_range(2, 22);
    r.sx = base_x + $signed($urandom_range(0, 2 * span)) - span;
    r.sy = base_y + $signed($urandom_range(0, 2 * span)) - span;
    r.ex = base_x + $signed($urandom_range(0, 2 * span)) - span;
    r.ey = base_y + $signed($urandom_range(0, 2 * span)) - span;
    r.qx = base_x + $signed($urandom_range(0, 4 * span)) - 2 * span;
    r.qy = base_y + $signed($urandom_range(0, 4 * span)) - 2 * span;
    case (kind)
      0, 1: begin
        r.qx = $urandom; r.qy = $urandom; r.sx = $urandom;
        r.sy = $urandom; r.ex = $urandom; r.ey = $urandom;
      end
      2: begin
        r.ex = r.sx + $signed($urandom_range(0, 64)) - 32;
        r.ey = r.sy + $signed($urandom_range(0, 64)) - 32;
      end
      3: begin
        r.qx = edge_coord(); r.qy = edge_coord(); r.sx = edge_coord();
        r.sy = edge_coord(); r.ex = edge_coord(); r.ey = edge_coord();
      end
      4: begin
        r.qx = r.sx + $signed($urandom_range(0, 8)) - 4;
        r.qy = r.sy + $signed($urandom_range(0, 8)) - 4;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic request_t make_request(int qx, int qy, int sx, int sy, int ex, int ey);
    request_t r;
    r.qx = qx; r.qy = qy; r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
    return r;
  endfunction

  task automatic run_directed();
    request_t r;
    int       mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    // Interior, clamped to start, clamped to end
    send_request(make_request(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0002_0000, 0));
    send_request(make_request(-32'h0001_0000, 32'h0000_8000, 0, 0, 32'h0002_0000, 0));
    send_request(make_request(32'h0005_0000, 32'h0000_0001, 0, 0, 32'h0002_0000, 0));
    // Degenerate: identical end points, and segments just under and just over the threshold
    send_request(make_request(32'h0003_0000, -32'h0004_0000, 7, 7, 7, 7));
    send_request(make_request(100, 100, 0, 0, 65, 0));
    send_request(make_request(100, 100, 0, 0, 66, 0));
    // Tiny positive projection still counts as interior
    send_request(make_request(1, 32'h4000_0000, 0, 0, 32'h4000_0000, 0));
    // Query exactly on an end point and on the start point
    send_request(make_request(32'h0002_0000, 0, 0, 0, 32'h0002_0000, 0));
    send_request(make_request(0, 0, 0, 0, 32'h0002_0000, 32'h0002_0000));
    // Extremes of every field
    send_request(make_request(mn, mn, mx, mx, mn, mn));
    send_request(make_request(mx, mx, mn, mn, mx, mx));
    send_request(make_request(mx, mn, mn, mx, mx, mn));
    send_request(make_request(0, 0, mn, mx, mx, mn));
    send_request(make_request(mn, mx, mn, mn, mx, mx));
    send_request(make_request(-1, -1, -1, 0, 0, -1));
    // Short diagonal segments: degenerate at the reset threshold, else interior points needing rounding in both
    send_request(make_request(3, 7, -5, -9, 11, 13));
    send_request(make_request(-3, 2, 10, -10, -10, 10));
    for (int i = 0; i < 6; i++) begin
      r = random_request();
      send_request(r);
    end
  endtask

  task automatic run_random(int count);
    request_t r;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 3 + 80);
      if (i == count / 2) drain();
      r = random_request();
      send_request(r);
      maybe_idle();
    end
  endtask

  initial begin
    sb          = new();
    cycles      = 0;
    sent        = 0;
    calm        = 1'b0;
    rst_ni      = 1'b1;
    start       = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    query_x_i   = '0; query_y_i = '0;
    start_x_i   = '0; start_y_i = '0;
    end_x_i     = '0; end_y_i   = '0;
    #1;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset threshold first, then sweep the register
    run_directed();
    run_random(400);
    write_min_sq('0);
    run_directed();
    run_random(300);
    write_min_sq('1);
    run_random(300);
    write_min_sq(32'h0010_0000);
    run_random(300);
    write_min_sq($urandom);
    run_random(200);
    write_min_sq(MinSqReset);
    run_random(300);

    drain();
    $display("Covered %0d requests over six threshold settings, all-zero and all-ones included.",
             sent);
    $display("Regions matched: interior %0d, start %0d, end %0d, degenerate %0d.",
             sb.region_seen[0], sb.region_seen[1], sb.region_seen[2], sb.region_seen[3]);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS point_segment_nearest_distance");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("FAIL point_segment_nearest_distance");
    end
    $finish;
  end
endmodule
